[design/fsr_pkg.sv]
// ----------------------------------------------------------------------------
// fsr_pkg - framed serial receiver shared definitions
// Sizes, codes and the structs passed between the parser and the top level.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam int SLOT_COUNT       = 4;
    localparam int PAYLOAD_CAPACITY = 256;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PIDX_W  = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
    localparam int ADDR_W  = SLOT_W + PIDX_W;
    localparam int MEM_DEPTH = SLOT_COUNT << PIDX_W;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 2'd1;

    localparam logic [BYTE_W-1:0] HEAD_BYTE_RST = 8'd126;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST = 8'd127;

    typedef enum logic [5:0] {
        PH_HEAD    = 6'b000001,
        PH_ID      = 6'b000010,
        PH_LEN     = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_TAIL    = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        FUNC_BYTE    = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RELEASE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TAIL_ERR = 2'd1,
        ST_SUM_ERR  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   checksum;
        logic                done;
        logic                avail;
        logic [BYTE_W-1:0]   length;
        logic [BYTE_W-1:0]   id;
        logic                rd_en;
    } t_result;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_cmd;

    // BSD checksum step: rotate right by one, then add
    function automatic logic [BYTE_W-1:0] bsd_step(input logic [BYTE_W-1:0] sum,
                                                   input logic [BYTE_W-1:0] b);
        return {sum[0], sum[BYTE_W-1:1]} + b;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOT_COUNT - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

endpackage

[design/fsr_payload_ram.sv]
// ----------------------------------------------------------------------------
// fsr_payload_ram - payload byte store
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module fsr_payload_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/fsr_parser.sv]
// ----------------------------------------------------------------------------
// fsr_parser - frame parser and message ring control
// Updates parse state and ring pointers per accepted word and forms the result.
// ----------------------------------------------------------------------------
module fsr_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsr_pkg::BYTE_W-1:0]         i_cfg_data,
    input  logic                               i_accept,
    input  logic [1:0]                         i_func,
    input  logic [fsr_pkg::BYTE_W-1:0]         i_byte_in,
    input  logic [fsr_pkg::BYTE_W-1:0]         i_read_index,
    output fsr_pkg::t_result                   o_result,
    output fsr_pkg::t_mem_cmd                  o_mem
);

    logic [fsr_pkg::BYTE_W-1:0] r_head_byte;
    logic [fsr_pkg::BYTE_W-1:0] r_tail_byte;

    fsr_pkg::t_phase             r_phase, n_phase;
    logic [fsr_pkg::BYTE_W-1:0]  r_count, n_count;
    logic [fsr_pkg::BYTE_W-1:0]  r_sum, n_sum;
    logic [fsr_pkg::BYTE_W-1:0]  r_cur_len, n_cur_len;
    logic [fsr_pkg::SLOT_W-1:0]  r_rd_slot, n_rd_slot;
    logic [fsr_pkg::SLOT_W-1:0]  r_wr_slot, n_wr_slot;

    logic [fsr_pkg::BYTE_W-1:0]  r_slot_ids     [fsr_pkg::SLOT_COUNT];
    logic [fsr_pkg::BYTE_W-1:0]  r_slot_lengths [fsr_pkg::SLOT_COUNT];

    logic                        id_we;
    logic                        len_we;
    logic                        avail;
    logic                        n_avail;
    logic [fsr_pkg::BYTE_W:0]    count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte <= fsr_pkg::HEAD_BYTE_RST;
            r_tail_byte <= fsr_pkg::TAIL_BYTE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsr_pkg::CFG_HEAD_BYTE: r_head_byte <= i_cfg_data;
                fsr_pkg::CFG_TAIL_BYTE: r_tail_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign avail     = (r_rd_slot != r_wr_slot);
    assign count_inc = {1'b0, r_count} + (fsr_pkg::BYTE_W+1)'(1);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_sum     = r_sum;
        n_cur_len = r_cur_len;
        n_rd_slot = r_rd_slot;
        n_wr_slot = r_wr_slot;
        id_we     = 1'b0;
        len_we    = 1'b0;

        o_result          = '0;
        o_result.status   = fsr_pkg::ST_OK;

        o_mem       = '0;
        o_mem.waddr = {r_wr_slot, r_count[fsr_pkg::PIDX_W-1:0]};
        o_mem.raddr = {r_rd_slot, i_read_index[fsr_pkg::PIDX_W-1:0]};
        o_mem.wdata = i_byte_in;

        if (i_accept) begin
            case (fsr_pkg::t_func'(i_func))
                fsr_pkg::FUNC_BYTE: begin
                    case (r_phase)
                        fsr_pkg::PH_HEAD: begin
                            if (i_byte_in == r_head_byte) begin
                                n_phase = fsr_pkg::PH_ID;
                            end
                        end
                        fsr_pkg::PH_ID: begin
                            id_we   = 1'b1;
                            n_phase = fsr_pkg::PH_LEN;
                        end
                        fsr_pkg::PH_LEN: begin
                            len_we    = 1'b1;
                            n_cur_len = i_byte_in;
                            n_sum     = '0;
                            n_count   = '0;
                            n_phase   = fsr_pkg::PH_PAYLOAD;
                        end
                        fsr_pkg::PH_PAYLOAD: begin
                            // bytes past capacity only feed the checksum
                            o_mem.we = ({1'b0, r_count} <
                                        (fsr_pkg::BYTE_W+1)'(fsr_pkg::PAYLOAD_CAPACITY));
                            n_sum    = fsr_pkg::bsd_step(r_sum, i_byte_in);
                            n_count  = count_inc[fsr_pkg::BYTE_W-1:0];
                            // a zero length still takes one byte
                            if (count_inc >= {1'b0, r_cur_len}) begin
                                n_phase = fsr_pkg::PH_TAIL;
                            end
                        end
                        fsr_pkg::PH_TAIL: begin
                            if (i_byte_in == r_tail_byte) begin
                                n_phase = fsr_pkg::PH_CHECK;
                            end else begin
                                n_phase         = fsr_pkg::PH_HEAD;
                                o_result.status = fsr_pkg::ST_TAIL_ERR;
                            end
                        end
                        fsr_pkg::PH_CHECK: begin
                            n_phase = fsr_pkg::PH_HEAD;
                            if (i_byte_in == r_sum) begin
                                // no full check: overrunning the reader empties the ring
                                n_wr_slot     = fsr_pkg::slot_inc(r_wr_slot);
                                o_result.done = 1'b1;
                            end else begin
                                o_result.status   = fsr_pkg::ST_SUM_ERR;
                                o_result.checksum = r_sum;
                            end
                        end
                        default: n_phase = fsr_pkg::PH_HEAD;
                    endcase
                end
                fsr_pkg::FUNC_READ: begin
                    if (!avail) begin
                        o_result.status = fsr_pkg::ST_EMPTY;
                    end else if ({1'b0, i_read_index} <
                                 (fsr_pkg::BYTE_W+1)'(fsr_pkg::PAYLOAD_CAPACITY)) begin
                        o_mem.re       = 1'b1;
                        o_result.rd_en = 1'b1;
                    end
                end
                fsr_pkg::FUNC_RELEASE: begin
                    if (!avail) begin
                        o_result.status = fsr_pkg::ST_EMPTY;
                    end else begin
                        n_rd_slot = fsr_pkg::slot_inc(r_rd_slot);
                    end
                end
                default: ;
            endcase
        end

        // head-of-ring view after this word
        n_avail         = (n_rd_slot != n_wr_slot);
        o_result.avail  = n_avail;
        o_result.length = n_avail ? r_slot_lengths[n_rd_slot] : '0;
        o_result.id     = n_avail ? r_slot_ids[n_rd_slot] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fsr_pkg::PH_HEAD;
            r_count   <= '0;
            r_sum     <= '0;
            r_cur_len <= '0;
            r_rd_slot <= '0;
            r_wr_slot <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_cur_len <= n_cur_len;
            r_rd_slot <= n_rd_slot;
            r_wr_slot <= n_wr_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_slot_ids[r_wr_slot] <= i_byte_in;
        end
        if (len_we) begin
            r_slot_lengths[r_wr_slot] <= i_byte_in;
        end
    end

endmodule

[design/framed_serial_receiver.sv]
// ----------------------------------------------------------------------------
// framed_serial_receiver - framed serial byte receiver with message ring
// Parses head/id/length/payload/tail/checksum frames and serves stored payload.
// ----------------------------------------------------------------------------
// The result passes the stage-one register, then the output (RAM read) stage.
// Throughput: one word per cycle unless output stalls; the parser updates its
// state in the accept cycle; the RAM read is registered once, so nothing loops.
// Reset: synchronous active low; clears parse state, ring pointers, pipeline
// valids and restores head byte 126 and tail byte 127. Stored data is not cleared.
module framed_serial_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fsr_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_byte_in,
    input  logic [7:0]                    i_read_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_frame_status,
    output logic [7:0]                    o_computed_checksum,
    output logic                          o_frame_done,
    output logic                          o_message_ready,
    output logic [7:0]                    o_ready_length,
    output logic [7:0]                    o_ready_id,
    output logic [7:0]                    o_read_byte
);

    logic                       accept;
    logic                       s2_load;
    fsr_pkg::t_result           parse_res;
    fsr_pkg::t_mem_cmd          mem_cmd;
    logic [fsr_pkg::BYTE_W-1:0] mem_rdata;

    logic                       r_s1_valid;
    fsr_pkg::t_result           r_s1_res;
    logic                       r_out_valid;
    fsr_pkg::t_result           r_out_res;
    logic [fsr_pkg::BYTE_W-1:0] r_out_rbyte;

    assign s2_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_load;
    assign accept     = i_in_valid && o_in_ready;

    fsr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_byte_in    (i_byte_in),
        .i_read_index (i_read_index),
        .o_result     (parse_res),
        .o_mem        (mem_cmd)
    );

    fsr_payload_ram #(
        .DEPTH  (fsr_pkg::MEM_DEPTH),
        .ADDR_W (fsr_pkg::ADDR_W),
        .DATA_W (fsr_pkg::BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_cmd.we),
        .i_waddr (mem_cmd.waddr),
        .i_wdata (mem_cmd.wdata),
        .i_re    (mem_cmd.re),
        .i_raddr (mem_cmd.raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // RAM read data stays put until the next read, which needs a new accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= parse_res;
        end
        if (s2_load) begin
            r_out_res   <= r_s1_res;
            r_out_rbyte <= r_s1_res.rd_en ? mem_rdata : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_status      = r_out_res.status;
    assign o_computed_checksum = r_out_res.checksum;
    assign o_frame_done        = r_out_res.done;
    assign o_message_ready     = r_out_res.avail;
    assign o_ready_length      = r_out_res.length;
    assign o_ready_id          = r_out_res.id;
    assign o_read_byte         = r_out_rbyte;

endmodule

[design/fsr_checker.sv]
// ----------------------------------------------------------------------------
// fsr_checker - port level checks for the framed serial receiver
// Watches the result channel for consistent status and head-of-ring fields.
// ----------------------------------------------------------------------------
module fsr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    o_frame_status,
    input  logic [7:0]                    o_computed_checksum,
    input  logic                          o_frame_done,
    input  logic                          o_message_ready,
    input  logic [7:0]                    o_ready_length,
    input  logic [7:0]                    o_ready_id,
    input  logic [7:0]                    o_read_byte
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_status)
            && $stable(o_read_byte) && $stable(o_ready_id))
        else $error("result word changed while stalled");

    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_frame_status == fsr_pkg::ST_OK)
        else $error("frame done with error status");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_message_ready |-> o_ready_length == 8'd0 && o_ready_id == 8'd0)
        else $error("head fields nonzero with empty ring");

    a_sum_only_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != fsr_pkg::ST_SUM_ERR |-> o_computed_checksum == 8'd0)
        else $error("checksum reported without checksum error");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status == fsr_pkg::ST_EMPTY |->
            !o_message_ready && o_read_byte == 8'd0 && !o_frame_done)
        else $error("empty status with message or data");

endmodule

bind framed_serial_receiver fsr_checker u_fsr_checker (.*);
